[rtl/core/h2r_pkg.sv]
// Shared types for the HSV to RGB converter.
package h2r_pkg;

	typedef enum logic [2:0] {
		SEC0 = 3'd0,
		SEC1 = 3'd1,
		SEC2 = 3'd2,
		SEC3 = 3'd3,
		SEC4 = 3'd4,
		SEC5 = 3'd5
	} sector_t;

	localparam logic [2:0] SECTOR_WRAP = 3'd6;

	typedef struct packed {
		logic    valid;
		sector_t sector;
	} stage_tag_t;

endpackage

[rtl/core/h2r_prep.sv]
// Stage 1: input clamp, hue times six, sector and fraction split.
module h2r_prep #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [FRAC_BITS:0]     hue,
	input  logic [FRAC_BITS:0]     sat,
	input  logic [FRAC_BITS:0]     val,
	output h2r_pkg::stage_tag_t    tag_s1,
	output logic [FRAC_BITS-1:0]   frac_s1,
	output logic [FRAC_BITS:0]     sat_s1,
	output logic [FRAC_BITS:0]     nsat_s1,
	output logic [FRAC_BITS:0]     val_s1
);
	import h2r_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	logic [W-1:0]         h_c;
	logic [W-1:0]         s_c;
	logic [W-1:0]         v_c;
	logic [FRAC_BITS+2:0] h6_c;
	logic [2:0]           sec_c;

	always_comb begin
		h_c   = (hue > ONE) ? ONE : hue;
		s_c   = (sat > ONE) ? ONE : sat;
		v_c   = (val > ONE) ? ONE : val;
		h6_c  = ({2'b00, h_c} << 2) + ({2'b00, h_c} << 1);
		sec_c = h6_c[FRAC_BITS+2:FRAC_BITS];
		if (sec_c == SECTOR_WRAP) begin
			sec_c = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.valid  <= in_valid;
			tag_s1.sector <= sector_t'(sec_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			frac_s1 <= h6_c[FRAC_BITS-1:0];
			sat_s1  <= s_c;
			nsat_s1 <= ONE - s_c;
			val_s1  <= v_c;
		end
	end

endmodule

[rtl/core/h2r_mul.sv]
// Stages 2 and 3: the two rounds of truncated products forming the levels.
module h2r_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en2,
	input  logic                   en3,
	input  h2r_pkg::stage_tag_t    tag_s1,
	input  logic [FRAC_BITS-1:0]   frac_s1,
	input  logic [FRAC_BITS:0]     sat_s1,
	input  logic [FRAC_BITS:0]     nsat_s1,
	input  logic [FRAC_BITS:0]     val_s1,
	output h2r_pkg::stage_tag_t    tag_s3,
	output logic [FRAC_BITS:0]     la_s3,
	output logic [FRAC_BITS:0]     lb_s3,
	output logic [FRAC_BITS:0]     lc_s3,
	output logic [FRAC_BITS:0]     val_s3
);
	import h2r_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam int PW = 2 * W;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	stage_tag_t   tag_s2;
	logic [W-1:0] fs_s2;
	logic [W-1:0] sf_s2;
	logic [W-1:0] la_s2;
	logic [W-1:0] val_s2;

	logic [PW-1:0] fs_p;
	logic [PW-1:0] sf_p;
	logic [PW-1:0] la_p;
	logic [PW-1:0] lb_p;
	logic [PW-1:0] lc_p;

	always_comb begin
		fs_p = PW'({1'b0, frac_s1}) * PW'(sat_s1);
		sf_p = PW'(sat_s1) * PW'(ONE - W'({1'b0, frac_s1}));
		la_p = PW'(val_s1) * PW'(nsat_s1);
		lb_p = PW'(val_s2) * PW'(ONE - fs_s2);
		lc_p = PW'(val_s2) * PW'(ONE - sf_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			if (en2) begin
				tag_s2 <= tag_s1;
			end
			if (en3) begin
				tag_s3 <= tag_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && tag_s1.valid) begin
			fs_s2  <= fs_p[2*FRAC_BITS:FRAC_BITS];
			sf_s2  <= sf_p[2*FRAC_BITS:FRAC_BITS];
			la_s2  <= la_p[2*FRAC_BITS:FRAC_BITS];
			val_s2 <= val_s1;
		end
		if (en3 && tag_s2.valid) begin
			la_s3  <= la_s2;
			lb_s3  <= lb_p[2*FRAC_BITS:FRAC_BITS];
			lc_s3  <= lc_p[2*FRAC_BITS:FRAC_BITS];
			val_s3 <= val_s2;
		end
	end

endmodule

[rtl/core/h2r_route.sv]
// Stage 4: routes the levels to the channels by sector into the output register.
module h2r_route #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  h2r_pkg::stage_tag_t    tag_s3,
	input  logic [FRAC_BITS:0]     la_s3,
	input  logic [FRAC_BITS:0]     lb_s3,
	input  logic [FRAC_BITS:0]     lc_s3,
	input  logic [FRAC_BITS:0]     val_s3,
	output logic                   valid_s4,
	output logic [FRAC_BITS:0]     red_s4,
	output logic [FRAC_BITS:0]     green_s4,
	output logic [FRAC_BITS:0]     blue_s4
);
	import h2r_pkg::*;

	localparam int W = FRAC_BITS + 1;

	logic [W-1:0] r_c;
	logic [W-1:0] g_c;
	logic [W-1:0] b_c;

	always_comb begin
		unique case (tag_s3.sector)
			SEC0: begin
				r_c = val_s3; g_c = lc_s3; b_c = la_s3;
			end
			SEC1: begin
				r_c = lb_s3; g_c = val_s3; b_c = la_s3;
			end
			SEC2: begin
				r_c = la_s3; g_c = val_s3; b_c = lc_s3;
			end
			SEC3: begin
				r_c = la_s3; g_c = lb_s3; b_c = val_s3;
			end
			SEC4: begin
				r_c = lc_s3; g_c = la_s3; b_c = val_s3;
			end
			default: begin
				r_c = val_s3; g_c = la_s3; b_c = lb_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= tag_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_s3.valid) begin
			red_s4   <= r_c;
			green_s4 <= g_c;
			blue_s4  <= b_c;
		end
	end

endmodule

[rtl/core/hsv_to_rgb_top.sv]
// HSV to RGB converter, four-stage pipeline with stream handshake.
// 4 register stages; each stage advances when empty or drained downstream.
// Throughput: one item per cycle while m_tready is high.
// Stage depth is set by the two chained truncated products of the lb and lc paths (stages 2 and 3).
// Reset clears all stage valid bits; data registers are not reset.
module hsv_to_rgb_top #(
	parameter int FRAC_BITS = 16,
	localparam int W = FRAC_BITS + 1,
	localparam int DW = ((3 * W + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,  // hue_in, sat_in, val_in, zero pad
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata   // red_out, green_out, blue_out, zero pad
);
	import h2r_pkg::*;

	stage_tag_t           tag_s1;
	stage_tag_t           tag_s3;
	logic [FRAC_BITS-1:0] frac_s1;
	logic [W-1:0]         sat_s1;
	logic [W-1:0]         nsat_s1;
	logic [W-1:0]         val_s1;
	logic [W-1:0]         la_s3;
	logic [W-1:0]         lb_s3;
	logic [W-1:0]         lc_s3;
	logic [W-1:0]         val_s3;
	logic                 valid_s4;
	logic [W-1:0]         red_s4;
	logic [W-1:0]         green_s4;
	logic [W-1:0]         blue_s4;
	logic                 valid_s2;
	logic                 en1;
	logic                 en2;
	logic                 en3;
	logic                 en4;

	// valid_s2 mirrors the stage-2 tag inside h2r_mul
	logic valid_s2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
		end else if (en2) begin
			valid_s2_q <= tag_s1.valid;
		end
	end

	assign valid_s2 = valid_s2_q;
	assign en4      = !valid_s4 || m_tready;
	assign en3      = !tag_s3.valid || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !tag_s1.valid || en2;
	assign s_tready = en1;

	h2r_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (s_tvalid),
		.hue      (s_tdata[W-1:0]),
		.sat      (s_tdata[2*W-1:W]),
		.val      (s_tdata[3*W-1:2*W]),
		.tag_s1   (tag_s1),
		.frac_s1  (frac_s1),
		.sat_s1   (sat_s1),
		.nsat_s1  (nsat_s1),
		.val_s1   (val_s1)
	);

	h2r_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en2     (en2),
		.en3     (en3),
		.tag_s1  (tag_s1),
		.frac_s1 (frac_s1),
		.sat_s1  (sat_s1),
		.nsat_s1 (nsat_s1),
		.val_s1  (val_s1),
		.tag_s3  (tag_s3),
		.la_s3   (la_s3),
		.lb_s3   (lb_s3),
		.lc_s3   (lc_s3),
		.val_s3  (val_s3)
	);

	h2r_route #(.FRAC_BITS(FRAC_BITS)) u_route (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en4),
		.tag_s3   (tag_s3),
		.la_s3    (la_s3),
		.lb_s3    (lb_s3),
		.lc_s3    (lc_s3),
		.val_s3   (val_s3),
		.valid_s4 (valid_s4),
		.red_s4   (red_s4),
		.green_s4 (green_s4),
		.blue_s4  (blue_s4)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = DW'({blue_s4, green_s4, red_s4});

endmodule
